// ===== rtl/alss_pkg.sv =====
`timescale 1ns / 1ps

package alss_pkg;

  // Number formats
  localparam int COORD_BITS = 13;
  localparam int FRAC_BITS  = 16;
  localparam int COV_BITS   = 8;

  localparam int COL_W     = COORD_BITS + 1;
  localparam int PIX_W     = COORD_BITS - 1;
  localparam int POS_W     = COORD_BITS + 2;
  localparam int SLOPE_W   = FRAC_BITS + 2;
  localparam int RUN_W     = COORD_BITS + FRAC_BITS + 1;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int CVW       = COV_BITS + 1;
  localparam int COLOR_W   = 24;
  localparam int DIV_STEPS = COORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CVW-1:0] COV_FULL = CVW'(1 << COV_BITS);
  localparam logic [CVW-1:0] COV_HALF = CVW'(1 << (COV_BITS - 1));
  localparam logic [QUO_W-1:0] SLOPE_ONE = QUO_W'(1 << FRAC_BITS);
  localparam logic [COORD_BITS-1:0] FB_MAX = COORD_BITS'(1 << PIX_W);

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Register map
  localparam int ADDR_W = 3;
  localparam logic REG_FB_WIDTH  = 1'b0;
  localparam logic REG_FB_HEIGHT = 1'b1;
  localparam logic [COORD_BITS-1:0] FB_WIDTH_RESET  = COORD_BITS'(1024);
  localparam logic [COORD_BITS-1:0] FB_HEIGHT_RESET = COORD_BITS'(768);

  // Command queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic                         cmd;
    logic                         steep;
    logic signed [COORD_BITS-1:0] u0;
    logic signed [COORD_BITS-1:0] v0;
    logic signed [COORD_BITS-1:0] u1;
    logic signed [COORD_BITS-1:0] v1;
    logic [COORD_BITS-1:0]        dx;
    logic [COORD_BITS-1:0]        dy_mag;
    logic                         dy_neg;
    logic [COLOR_W-1:0]           color;
  } qent_t;

  typedef struct packed {
    logic             vld;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [CVW-1:0]   cov;
  } slot_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] width;
    logic [COORD_BITS-1:0] height;
  } fb_cfg_t;

  // Build one pixel slot from major/minor position, swapping back for steep lines and clipping
  function automatic slot_t make_slot(input logic signed [POS_W-1:0] u,
                                      input logic signed [POS_W-1:0] v,
                                      input logic [CVW-1:0] cov,
                                      input logic steep,
                                      input fb_cfg_t fb);
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] w;
    logic signed [POS_W-1:0] h;
    slot_t s;
    x = steep ? v : u;
    y = steep ? u : v;
    w = (fb.width  > FB_MAX) ? POS_W'(FB_MAX) : POS_W'(fb.width);
    h = (fb.height > FB_MAX) ? POS_W'(FB_MAX) : POS_W'(fb.height);
    s = '0;
    if (cov != '0 && x >= 0 && x < w && y >= 0 && y < h) begin
      s.vld = 1'b1;
      s.x   = x[PIX_W-1:0];
      s.y   = y[PIX_W-1:0];
      s.cov = cov;
    end
    return s;
  endfunction

endpackage

// ===== rtl/alss_front.sv =====
`timescale 1ns / 1ps

module alss_front (
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_cmd,
  input  logic signed [alss_pkg::COORD_BITS-1:0] in_x_start,
  input  logic signed [alss_pkg::COORD_BITS-1:0] in_y_start,
  input  logic signed [alss_pkg::COORD_BITS-1:0] in_x_end,
  input  logic signed [alss_pkg::COORD_BITS-1:0] in_y_end,
  input  logic [alss_pkg::COLOR_W-1:0]          in_color,
  input  logic                                  q_full,
  output logic                                  q_push,
  output alss_pkg::qent_t                       q_din
);

  localparam int CW = alss_pkg::COL_W;
  localparam int KW = alss_pkg::COORD_BITS;

  logic signed [CW-1:0] xs, ys, xe, ye;
  logic signed [CW-1:0] ddx, ddy, adx, ady;
  logic signed [CW-1:0] a0, b0, a1, b1;
  logic signed [CW-1:0] u0, v0, u1, v1;
  logic signed [CW-1:0] dx, dy, dy_abs;
  logic                 steep;

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the line: steepness, axis swap and endpoint order
  always_comb begin
    xs  = {in_x_start[KW-1], in_x_start};
    ys  = {in_y_start[KW-1], in_y_start};
    xe  = {in_x_end[KW-1], in_x_end};
    ye  = {in_y_end[KW-1], in_y_end};
    ddx = xe - xs;
    ddy = ye - ys;
    adx = (ddx < 0) ? -ddx : ddx;
    ady = (ddy < 0) ? -ddy : ddy;
    steep = ady > adx;
    a0 = steep ? ys : xs;
    b0 = steep ? xs : ys;
    a1 = steep ? ye : xe;
    b1 = steep ? xe : ye;
    if (a0 > a1) begin
      u0 = a1; v0 = b1; u1 = a0; v1 = b0;
    end else begin
      u0 = a0; v0 = b0; u1 = a1; v1 = b1;
    end
    dx     = u1 - u0;
    dy     = v1 - v0;
    dy_abs = (dy < 0) ? -dy : dy;

    q_din.cmd    = in_cmd;
    q_din.steep  = steep;
    q_din.u0     = u0[KW-1:0];
    q_din.v0     = v0[KW-1:0];
    q_din.u1     = u1[KW-1:0];
    q_din.v1     = v1[KW-1:0];
    q_din.dx     = dx[KW-1:0];
    q_din.dy_mag = dy_abs[KW-1:0];
    q_din.dy_neg = dy < 0;
    q_din.color  = in_color;
  end

endmodule

// ===== rtl/alss_fifo.sv =====
`timescale 1ns / 1ps

module alss_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  alss_pkg::qent_t din,
  input  logic            pop,
  output logic            vld,
  output logic            full,
  output alss_pkg::qent_t dout
);

  alss_pkg::qent_t                 mem_r [alss_pkg::Q_DEPTH];
  logic [alss_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [alss_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [alss_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  assign vld  = cnt_r != '0;
  assign full = cnt_r == alss_pkg::Q_CNT_W'(alss_pkg::Q_DEPTH);
  assign dout = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// ===== rtl/alss_back.sv =====
`timescale 1ns / 1ps

module alss_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_vld,
  input  alss_pkg::qent_t                  q_head,
  output logic                             q_pop,
  input  alss_pkg::fb_cfg_t                fb,
  output logic                             out_valid,
  input  logic                             out_ready,
  output alss_pkg::slot_t                  out_a,
  output alss_pkg::slot_t                  out_b,
  output logic [alss_pkg::COLOR_W-1:0]     out_color,
  output logic                             out_done
);

  localparam int KW = alss_pkg::COORD_BITS;
  localparam int CW = alss_pkg::COL_W;
  localparam int PW = alss_pkg::POS_W;
  localparam int SW = alss_pkg::SLOPE_W;
  localparam int RW = alss_pkg::RUN_W;
  localparam int QW = alss_pkg::QUO_W;
  localparam int FB = alss_pkg::FRAC_BITS;
  localparam int DS = alss_pkg::DIV_STEPS;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } st_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_END   = 4'b0100,
    PH_INNER = 4'b1000
  } ph_t;

  st_t                  state_r, state_nxt;
  ph_t                  phase_r, phase_nxt;
  logic                 steep_r, steep_nxt;
  logic signed [CW-1:0] column_r, column_nxt;
  logic signed [CW-1:0] last_col_r, last_col_nxt;
  logic signed [KW-1:0] start_row_r, start_row_nxt;
  logic signed [KW-1:0] end_row_r, end_row_nxt;
  logic signed [RW-1:0] run_y_r, run_y_nxt;
  logic signed [SW-1:0] slope_r, slope_nxt;
  logic [alss_pkg::COLOR_W-1:0] color_r, color_nxt;

  // Gradient divider
  logic [KW-1:0]        rem_r, rem_nxt;
  logic [DS-1:0]        dvd_r, dvd_nxt;
  logic [QW-1:0]        quo_r, quo_nxt;
  logic [alss_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0]        dx_r, dx_nxt;
  logic                 dy_neg_r, dy_neg_nxt;

  // Result register
  logic                 out_vld_r, out_vld_nxt;
  alss_pkg::slot_t      a_r, a_nxt, b_r, b_nxt;
  logic [alss_pkg::COLOR_W-1:0] ocol_r, ocol_nxt;
  logic                 done_r, done_nxt;

  logic                 out_free;
  logic [KW:0]          rem_sh;
  logic                 ge;
  logic [KW:0]          rem_sub;
  logic [QW-1:0]        quo_step;
  logic [QW-1:0]        slope_mag;
  logic signed [SW-1:0] slope_new;
  logic signed [CW-1:0] fl;
  logic [alss_pkg::COV_BITS-1:0] frac;
  logic signed [CW-1:0] col_inc, last_dec;
  logic signed [PW-1:0] fl_pos;

  assign out_valid = out_vld_r;
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_color = ocol_r;
  assign out_done  = done_r;
  assign out_free  = !out_vld_r || out_ready;

  always_comb begin
    // Divider step: shift in one dividend bit, subtract when it fits
    rem_sh    = {rem_r, dvd_r[DS-1]};
    ge        = rem_sh >= {1'b0, dx_r};
    rem_sub   = rem_sh - {1'b0, dx_r};
    quo_step  = {quo_r[QW-2:0], ge};
    slope_mag = (dx_r == '0) ? alss_pkg::SLOPE_ONE : quo_step;
    slope_new = dy_neg_r ? -$signed({1'b0, slope_mag}) : $signed({1'b0, slope_mag});

    // Floor row and coverage fraction of the running y
    fl      = run_y_r[RW-1:FB];
    frac    = run_y_r[FB-1 -: alss_pkg::COV_BITS];
    fl_pos  = {fl[CW-1], fl};
    col_inc = column_r + 1'b1;
    last_dec = last_col_r - 1'b1;

    state_nxt     = state_r;
    phase_nxt     = phase_r;
    steep_nxt     = steep_r;
    column_nxt    = column_r;
    last_col_nxt  = last_col_r;
    start_row_nxt = start_row_r;
    end_row_nxt   = end_row_r;
    run_y_nxt     = run_y_r;
    slope_nxt     = slope_r;
    color_nxt     = color_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    dx_nxt        = dx_r;
    dy_neg_nxt    = dy_neg_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ocol_nxt      = ocol_r;
    done_nxt      = done_r;
    q_pop         = 1'b0;

    case (state_r)
      ST_RUN: begin
        if (q_vld && q_head.cmd == alss_pkg::CMD_LOAD) begin
          // Take the line set-up and start the gradient division
          q_pop         = 1'b1;
          steep_nxt     = q_head.steep;
          column_nxt    = {q_head.u0[KW-1], q_head.u0};
          last_col_nxt  = {q_head.u1[KW-1], q_head.u1};
          start_row_nxt = q_head.v0;
          end_row_nxt   = q_head.v1;
          color_nxt     = q_head.color;
          phase_nxt     = PH_START;
          dx_nxt        = q_head.dx;
          dy_neg_nxt    = q_head.dy_neg;
          rem_nxt       = '0;
          dvd_nxt       = {q_head.dy_mag, {FB{1'b0}}};
          quo_nxt       = '0;
          cnt_nxt       = '0;
          state_nxt     = ST_DIV;
        end else if (q_vld && out_free) begin
          // Step one column into the result register
          q_pop       = 1'b1;
          out_vld_nxt = 1'b1;
          ocol_nxt    = color_r;
          a_nxt       = '0;
          b_nxt       = '0;
          done_nxt    = 1'b0;
          case (phase_r)
            PH_IDLE: begin
              done_nxt = 1'b1;
            end
            PH_START: begin
              a_nxt = alss_pkg::make_slot({column_r[CW-1], column_r},
                                          {{(PW-KW){start_row_r[KW-1]}}, start_row_r},
                                          alss_pkg::COV_HALF, steep_r, fb);
              phase_nxt = PH_END;
            end
            PH_END: begin
              a_nxt = alss_pkg::make_slot({last_col_r[CW-1], last_col_r},
                                          {{(PW-KW){end_row_r[KW-1]}}, end_row_r},
                                          alss_pkg::COV_HALF, steep_r, fb);
              column_nxt   = col_inc;
              last_col_nxt = last_dec;
              if (last_dec < col_inc) begin
                done_nxt  = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_INNER;
              end
            end
            PH_INNER: begin
              a_nxt = alss_pkg::make_slot({column_r[CW-1], column_r}, fl_pos,
                                          alss_pkg::COV_FULL - {1'b0, frac}, steep_r, fb);
              b_nxt = alss_pkg::make_slot({column_r[CW-1], column_r}, fl_pos + 1'b1,
                                          {1'b0, frac}, steep_r, fb);
              if (column_r >= last_col_r) begin
                done_nxt  = 1'b1;
                phase_nxt = PH_IDLE;
              end
              column_nxt = col_inc;
              run_y_nxt  = run_y_r + {{(RW-SW){slope_r[SW-1]}}, slope_r};
            end
            default: begin
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        // Iterate the division one quotient bit a cycle
        rem_nxt = ge ? rem_sub[KW-1:0] : rem_sh[KW-1:0];
        dvd_nxt = {dvd_r[DS-2:0], 1'b0};
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == alss_pkg::DIV_CNT_W'(DS - 1)) begin
          slope_nxt = slope_new;
          run_y_nxt = {{(RW-KW-FB){start_row_r[KW-1]}}, start_row_r, {FB{1'b0}}}
                      + {{(RW-SW){slope_new[SW-1]}}, slope_new};
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // Control and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      phase_r     <= PH_IDLE;
      steep_r     <= 1'b0;
      column_r    <= '0;
      last_col_r  <= '0;
      start_row_r <= '0;
      end_row_r   <= '0;
      run_y_r     <= '0;
      slope_r     <= '0;
      color_r     <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      steep_r     <= steep_nxt;
      column_r    <= column_nxt;
      last_col_r  <= last_col_nxt;
      start_row_r <= start_row_nxt;
      end_row_r   <= end_row_nxt;
      run_y_r     <= run_y_nxt;
      slope_r     <= slope_nxt;
      color_r     <= color_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Divider and result payload
  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    dvd_r    <= dvd_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    dx_r     <= dx_nxt;
    dy_neg_r <= dy_neg_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    ocol_r   <= ocol_nxt;
    done_r   <= done_nxt;
  end

endmodule

// ===== rtl/antialiased_line_stepper_core.sv =====
`timescale 1ns / 1ps

// Channel   | Handshake             | Payload
// ----------+-----------------------+------------------------------------------------
// in_       | in_valid / in_ready   | cmd, x_start, y_start, x_end, y_end, color
// out_      | out_valid / out_ready | a_*, b_*, pixel_color, line_done
// config    | psel/penable/pwrite   | paddr 0 fb_width, 4 fb_height (13 bits each)
//
// Step transfers run at one per cycle while the output register is free to take them.
// A load is taken by the back end, which then runs the bit-serial gradient
// divider; items queued behind it wait.
// Reset is synchronous, active low; it empties the two-entry command queue.
// The output register holds a result until taken; the queue fills meanwhile.

module antialiased_line_stepper_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_cmd,
  input  logic signed [alss_pkg::COORD_BITS-1:0] in_x_start,
  input  logic signed [alss_pkg::COORD_BITS-1:0] in_y_start,
  input  logic signed [alss_pkg::COORD_BITS-1:0] in_x_end,
  input  logic signed [alss_pkg::COORD_BITS-1:0] in_y_end,
  input  logic [alss_pkg::COLOR_W-1:0]           in_color,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_a_valid,
  output logic [alss_pkg::PIX_W-1:0]             out_a_x,
  output logic [alss_pkg::PIX_W-1:0]             out_a_y,
  output logic [alss_pkg::CVW-1:0]               out_a_coverage,
  output logic                                   out_b_valid,
  output logic [alss_pkg::PIX_W-1:0]             out_b_x,
  output logic [alss_pkg::PIX_W-1:0]             out_b_y,
  output logic [alss_pkg::CVW-1:0]               out_b_coverage,
  output logic [alss_pkg::COLOR_W-1:0]           out_pixel_color,
  output logic                                   out_line_done,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [alss_pkg::ADDR_W-1:0]            paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int KW = alss_pkg::COORD_BITS;

  logic [KW-1:0]      fb_width_r, fb_width_nxt;
  logic [KW-1:0]      fb_height_r, fb_height_nxt;
  alss_pkg::fb_cfg_t  fb;
  logic               wr_en;

  logic               q_push, q_pop, q_vld, q_full;
  alss_pkg::qent_t    q_din, q_head;
  alss_pkg::slot_t    slot_a, slot_b;

  // Configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    fb_width_nxt  = fb_width_r;
    fb_height_nxt = fb_height_r;
    if (wr_en) begin
      case (paddr[2])
        alss_pkg::REG_FB_WIDTH:  fb_width_nxt  = pwdata[KW-1:0];
        alss_pkg::REG_FB_HEIGHT: fb_height_nxt = pwdata[KW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      alss_pkg::REG_FB_WIDTH:  prdata = {{(32-KW){1'b0}}, fb_width_r};
      alss_pkg::REG_FB_HEIGHT: prdata = {{(32-KW){1'b0}}, fb_height_r};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_width_r  <= alss_pkg::FB_WIDTH_RESET;
      fb_height_r <= alss_pkg::FB_HEIGHT_RESET;
    end else begin
      fb_width_r  <= fb_width_nxt;
      fb_height_r <= fb_height_nxt;
    end
  end

  assign fb.width  = fb_width_r;
  assign fb.height = fb_height_r;

  // Front end: accept and classify
  alss_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_x_start (in_x_start),
    .in_y_start (in_y_start),
    .in_x_end   (in_x_end),
    .in_y_end   (in_y_end),
    .in_color   (in_color),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_din      (q_din)
  );

  // Command queue
  alss_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .vld   (q_vld),
    .full  (q_full),
    .dout  (q_head)
  );

  // Back end: divider, stepper and result register
  alss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .fb        (fb),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_a     (slot_a),
    .out_b     (slot_b),
    .out_color (out_pixel_color),
    .out_done  (out_line_done)
  );

  assign out_a_valid    = slot_a.vld;
  assign out_a_x        = slot_a.x;
  assign out_a_y        = slot_a.y;
  assign out_a_coverage = slot_a.cov;
  assign out_b_valid    = slot_b.vld;
  assign out_b_x        = slot_b.x;
  assign out_b_y        = slot_b.y;
  assign out_b_coverage = slot_b.cov;

endmodule
